FILE: rtl/cms_pkg.sv
// Shared types and constants for the closure motion sequencer.
package cms_pkg;

    localparam int TICKS_W = 20;
    localparam int POS_W   = 14;

    localparam logic [POS_W-1:0] POS_PEDESTRIAN  = 14'd3000;
    localparam logic [POS_W-1:0] POS_SIGNATURE   = 14'd2000;
    localparam logic [POS_W-1:0] POS_VENTILATION = 14'd1000;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_CAL  = 2'd1,
        CMD_STOP = 2'd2,
        CMD_MOVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_CAL  = 2'd1,
        ACT_STOP = 2'd2,
        ACT_MOVE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        TLATCH_NONE     = 2'd0,
        TLATCH_UNLATCH  = 2'd1,
        TLATCH_LATCH    = 2'd2
    } tlatch_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_CALIBRATED   = 3'd1,
        EV_CAL_STOPPED  = 3'd2,
        EV_MOVE_STOPPED = 3'd3,
        EV_MOVE_DONE    = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        CODE_CLOSED     = 3'd0,
        CODE_OPEN       = 3'd1,
        CODE_PEDESTRIAN = 3'd2,
        CODE_SIGNATURE  = 3'd3,
        CODE_VENTILATION = 3'd4
    } code_t;

    typedef enum logic [1:0] {
        REG_CALIBRATE_TICKS = 2'd0,
        REG_MOTION_TICKS    = 2'd1,
        REG_STEP_SIZE       = 2'd2
    } reg_index_t;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_POS = 1'b1;

    typedef struct packed {
        logic [TICKS_W-1:0] calibrate_ticks;
        logic [TICKS_W-1:0] motion_ticks;
        logic [POS_W-1:0]   step_size;
    } cfg_t;

    typedef struct packed {
        logic       latch_wanted;
        logic       latch_given;
        logic [2:0] position_code;
        logic       position_given;
        logic [1:0] cmd;
    } item_t;

    // Packed so that the low bits match the stream word layout.
    typedef struct packed {
        logic             moving;
        logic             latched;
        logic [POS_W-1:0] panel_b_position;
        logic [POS_W-1:0] panel_a_position;
        logic [2:0]       event_res;
        logic             status;
    } result_t;

endpackage

FILE: rtl/cms_cfg_regs.sv
// Configuration register file of the closure motion sequencer.
module cms_cfg_regs
    import cms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [TICKS_W-1:0]  cfg_data,
    output cfg_t                cfg
);

    logic [TICKS_W-1:0] calibrate_ticks_reg;
    logic [TICKS_W-1:0] motion_ticks_reg;
    logic [POS_W-1:0]   step_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calibrate_ticks_reg <= 20'd10000;
            motion_ticks_reg    <= 20'd1000;
            step_size_reg       <= 14'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CALIBRATE_TICKS: calibrate_ticks_reg <= cfg_data;
                REG_MOTION_TICKS:    motion_ticks_reg    <= cfg_data;
                REG_STEP_SIZE:       step_size_reg       <= cfg_data[POS_W-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg.calibrate_ticks = calibrate_ticks_reg;
    assign cfg.motion_ticks    = motion_ticks_reg;
    assign cfg.step_size       = step_size_reg;

endmodule

FILE: rtl/cms_core.sv
// Sequencer state and the single-pass update for one command or tick.
module cms_core
    import cms_pkg::*;
#(
    parameter int POSITION_FULL = 10000
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam logic [POS_W-1:0] FULL_POS = POS_W'(POSITION_FULL);
    localparam logic [POS_W-1:0] TGT_PED  =
        (3000 > POSITION_FULL) ? FULL_POS : POS_PEDESTRIAN;
    localparam logic [POS_W-1:0] TGT_SIG  =
        (2000 > POSITION_FULL) ? FULL_POS : POS_SIGNATURE;
    localparam logic [POS_W-1:0] TGT_VENT =
        (1000 > POSITION_FULL) ? FULL_POS : POS_VENTILATION;

    action_t            action_reg, action_next;
    logic               calibrating_reg, calibrating_next;
    logic               motion_reg, motion_next;
    logic               timer_reg, timer_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;
    logic [POS_W-1:0]   pos_a_reg, pos_a_next;
    logic [POS_W-1:0]   pos_b_reg, pos_b_next;
    logic [POS_W-1:0]   target_reg, target_next;
    logic               target_valid_reg, target_valid_next;
    logic               latch_reg, latch_next;
    tlatch_t            tlatch_reg, tlatch_next;

    logic [POS_W-1:0]   step_a, step_b;
    logic               more_a, more_b;
    logic [POS_W-1:0]   map_target;
    logic               map_ok;
    event_t             ev;
    logic               status;

    // One step of a panel toward the shared target, clamped at the target.
    function automatic logic [POS_W:0] step_panel(
        input logic [POS_W-1:0] cur,
        input logic [POS_W-1:0] tgt,
        input logic             tvalid,
        input logic [POS_W-1:0] step
    );
        logic [POS_W-1:0] diff;
        logic [POS_W-1:0] nxt;
        logic             more;
        diff = (cur < tgt) ? (tgt - cur) : (cur - tgt);
        nxt  = cur;
        more = 1'b0;
        if (tvalid && (cur != tgt))
        begin
            if (diff <= step)
                nxt = tgt;
            else
            begin
                nxt  = (cur < tgt) ? (cur + step) : (cur - step);
                more = 1'b1;
            end
        end
        return {more, nxt};
    endfunction

    assign {more_a, step_a} = step_panel(pos_a_reg, target_reg, target_valid_reg, cfg.step_size);
    assign {more_b, step_b} = step_panel(pos_b_reg, target_reg, target_valid_reg, cfg.step_size);

    always_comb
    begin
        map_ok     = 1'b1;
        map_target = '0;
        if (item.position_given)
        begin
            case (item.position_code)
                CODE_CLOSED:      map_target = FULL_POS;
                CODE_OPEN:        map_target = '0;
                CODE_PEDESTRIAN:  map_target = TGT_PED;
                CODE_SIGNATURE:   map_target = TGT_SIG;
                CODE_VENTILATION: map_target = TGT_VENT;
                default:          map_ok = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        action_next       = action_reg;
        calibrating_next  = calibrating_reg;
        motion_next       = motion_reg;
        timer_next        = timer_reg;
        ticks_next        = ticks_reg;
        pos_a_next        = pos_a_reg;
        pos_b_next        = pos_b_reg;
        target_next       = target_reg;
        target_valid_next = target_valid_reg;
        latch_next        = latch_reg;
        tlatch_next       = tlatch_reg;
        ev                = EV_NONE;
        status            = STATUS_OK;

        case (cmd_t'(item.cmd))
            CMD_TICK:
            begin
                if (timer_reg)
                begin
                    if (ticks_reg <= TICKS_W'(1))
                    begin
                        timer_next = 1'b0;
                        ticks_next = '0;
                        if (action_reg == ACT_CAL)
                        begin
                            calibrating_next = 1'b0;
                            action_next      = ACT_NONE;
                            ev               = EV_CALIBRATED;
                        end
                        else if (action_reg == ACT_MOVE)
                        begin
                            // Unlatch comes before the panels step.
                            if (tlatch_reg == TLATCH_UNLATCH)
                                latch_next = 1'b0;
                            pos_a_next = step_a;
                            pos_b_next = step_b;
                            if (more_a || more_b)
                            begin
                                action_next = ACT_MOVE;
                                motion_next = 1'b1;
                                timer_next  = 1'b1;
                                ticks_next  = cfg.motion_ticks;
                            end
                            else
                            begin
                                if (tlatch_reg == TLATCH_LATCH)
                                    latch_next = 1'b1;
                                motion_next = 1'b0;
                                action_next = ACT_NONE;
                                ev          = EV_MOVE_DONE;
                            end
                        end
                    end
                    else
                        ticks_next = ticks_reg - TICKS_W'(1);
                end
            end
            CMD_CAL:
            begin
                action_next      = ACT_CAL;
                calibrating_next = 1'b1;
                timer_next       = 1'b1;
                ticks_next       = cfg.calibrate_ticks;
            end
            CMD_STOP:
            begin
                timer_next  = 1'b0;
                ticks_next  = '0;
                action_next = ACT_STOP;
                if (calibrating_reg)
                begin
                    calibrating_next = 1'b0;
                    ev               = EV_CAL_STOPPED;
                end
                else if (motion_reg)
                begin
                    motion_next = 1'b0;
                    ev          = EV_MOVE_STOPPED;
                end
            end
            default:
            begin
                timer_next = 1'b0;
                ticks_next = '0;
                if (!map_ok)
                    status = STATUS_BAD_POS;
                else
                begin
                    if (item.position_given)
                    begin
                        target_next       = map_target;
                        target_valid_next = 1'b1;
                    end
                    if (item.latch_given)
                        tlatch_next = item.latch_wanted ? TLATCH_LATCH : TLATCH_UNLATCH;
                    action_next = ACT_MOVE;
                    motion_next = 1'b1;
                    timer_next  = 1'b1;
                    ticks_next  = cfg.motion_ticks;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg       <= ACT_NONE;
            calibrating_reg  <= 1'b0;
            motion_reg       <= 1'b0;
            timer_reg        <= 1'b0;
            ticks_reg        <= '0;
            pos_a_reg        <= '0;
            pos_b_reg        <= '0;
            target_reg       <= '0;
            target_valid_reg <= 1'b0;
            latch_reg        <= 1'b0;
            tlatch_reg       <= TLATCH_NONE;
        end
        else if (fire)
        begin
            action_reg       <= action_next;
            calibrating_reg  <= calibrating_next;
            motion_reg       <= motion_next;
            timer_reg        <= timer_next;
            ticks_reg        <= ticks_next;
            pos_a_reg        <= pos_a_next;
            pos_b_reg        <= pos_b_next;
            target_reg       <= target_next;
            target_valid_reg <= target_valid_next;
            latch_reg        <= latch_next;
            tlatch_reg       <= tlatch_next;
        end
    end

    assign result.status           = status;
    assign result.event_res        = ev;
    assign result.panel_a_position = pos_a_next;
    assign result.panel_b_position = pos_b_next;
    assign result.latched          = latch_next;
    assign result.moving           = motion_next;

    // Every path that stops the timer also clears the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        !timer_reg |-> (ticks_reg == '0))
        else $error("idle timer holds a nonzero count");

    // Panels only ever move toward a target that is within range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_a_reg <= FULL_POS) && (pos_b_reg <= FULL_POS) && (target_reg <= FULL_POS))
        else $error("panel position or target beyond full travel");

    // A finished move leaves no motion pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (ev == EV_MOVE_DONE)) |=> (!motion_reg && !timer_reg))
        else $error("move reported done while motion continues");

endmodule

FILE: rtl/cms_out_buf.sv
// Two-entry output buffer that decouples result beats from downstream stalls.
module cms_out_buf
    import cms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    main_load;

    assign in_ready  = !skid_valid_reg;
    assign main_load = out_ready || !main_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_load)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                main_valid_reg <= in_fire;
        end
        else if (in_fire)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        else if (in_fire)
            skid_reg <= in_data;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // The spare entry is only used behind an occupied main entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("spare entry full while main entry is empty");

endmodule

FILE: rtl/closure_motion_sequencer_core.sv
// Top level of the closure motion sequencer: config port, state update, result buffer.
//
//  channel  | signals                            | payload
//  ---------+------------------------------------+-------------------------------------
//  command  | s_tvalid s_tready s_tdata s_tuser  | tuser: cmd; tdata: position/latch
//  result   | m_tvalid m_tready m_tdata          | status, event, positions, flags
//  config   | cfg_valid cfg_ready cfg_index/data | one register write per beat
//
// Each command or tick beat is one state update, taken every cycle while s_tready is high.
// Its result beat appears on m_tdata in the cycle after acceptance, unless an earlier
// result beat is still waiting there, in which case it follows once that one is taken.
// The result side holds two beats, so s_tready drops only once two results wait.
// Reset restores the default register values and the fully open, unlatched state.
module closure_motion_sequencer_core
    import cms_pkg::*;
#(
    parameter int POSITION_FULL = 10000
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // position_given, position_code[2:0], latch_given,
                                          // latch_wanted, zero fill
    input  logic [1:0]         s_tuser,   // cmd[1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // status, event_res[2:0], panel_a_position[13:0],
                                          // panel_b_position[13:0], latched, moving, zero fill
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [TICKS_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item;
    result_t core_result;
    result_t buf_result;
    logic    fire;

    assign fire = s_tvalid && s_tready;

    assign item.cmd            = s_tuser;
    assign item.position_given = s_tdata[0];
    assign item.position_code  = s_tdata[3:1];
    assign item.latch_given    = s_tdata[4];
    assign item.latch_wanted   = s_tdata[5];

    cms_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cms_core #(
        .POSITION_FULL (POSITION_FULL)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (core_result)
    );

    cms_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (fire),
        .in_data   (core_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_result)
    );

    assign m_tdata = {6'd0, buf_result};

endmodule
